@@ src/fmn_pkg.sv @@
// Shared constants, types and the semitone ratio table for the frequency-to-note unit.
package fmn_pkg;

    localparam int FREQ_W      = 16;
    localparam int NOTE_W      = 7;
    localparam int FRAC_W      = 8;                        // 16.8 fixed point
    localparam int TARGET_W    = FREQ_W + FRAC_W;          // scaled frequency
    localparam int BASE_W      = TARGET_W + 1;             // octave base, may exceed target
    localparam int RATIO_W     = 11;
    localparam int RATIO_SHIFT = 10;                       // ratios are times 1024
    localparam int PROD_W      = BASE_W + RATIO_W;
    localparam int LEVEL_W     = PROD_W - RATIO_SHIFT;
    localparam int SEMI_W      = 4;
    localparam int OCT_W       = 5;                        // octave offset -9..+7
    localparam int SUM_W       = 9;                        // signed note before clamp

    localparam logic [SEMI_W-1:0] LAST_SEMI = SEMI_W'(11);
    localparam logic [BASE_W-1:0] BASE_A4   = BASE_W'(440 * 256);
    localparam logic signed [SUM_W-1:0] NOTE_A4    = SUM_W'(69);
    localparam logic signed [SUM_W-1:0] NOTE_MAX   = SUM_W'(127);
    localparam logic signed [SUM_W-1:0] SEMIS_OCT  = SUM_W'(12);

    // Equal-tempered semitone ratios, times 1024
    function automatic logic [RATIO_W-1:0] semi_ratio(input logic [SEMI_W-1:0] idx);
        logic [RATIO_W-1:0] r;
        case (idx)
            4'd0:    r = 11'd1024;
            4'd1:    r = 11'd1085;
            4'd2:    r = 11'd1149;
            4'd3:    r = 11'd1217;
            4'd4:    r = 11'd1290;
            4'd5:    r = 11'd1366;
            4'd6:    r = 11'd1448;
            4'd7:    r = 11'd1534;
            4'd8:    r = 11'd1625;
            4'd9:    r = 11'd1722;
            4'd10:   r = 11'd1824;
            4'd11:   r = 11'd1933;
            default: r = 11'd1024;
        endcase
        return r;
    endfunction

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture input word, reset search
        logic dbl;      // double the octave base
        logic hlv;      // halve the octave base
        logic mul;      // form the level of the current semitone
        logic cmp;      // compare level with target, advance semitone
        logic out;      // load the result register
    } fmn_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero;       // silence, skip the search
        logic need_dbl;   // target >= 2 * base
        logic need_hlv;   // target < base
        logic last_semi;  // comparing the top semitone
    } fmn_status_t;

endpackage

@@ src/fmn_datapath.sv @@
// Datapath: octave base search, semitone level multiplier, nearest-level tracking, result register.
module fmn_datapath (
    input  logic                        aclk,
    input  fmn_pkg::fmn_cmd_t           cmd,
    output fmn_pkg::fmn_status_t        status,
    input  logic [fmn_pkg::FREQ_W-1:0]  s_freq_hz,
    output logic [fmn_pkg::NOTE_W-1:0]  m_note
);

    logic [fmn_pkg::TARGET_W-1:0]     target_reg;
    logic [fmn_pkg::BASE_W-1:0]       base_reg;
    logic signed [fmn_pkg::OCT_W-1:0] oct_reg;
    logic [fmn_pkg::SEMI_W-1:0]       semi_reg;
    logic [fmn_pkg::SEMI_W-1:0]       best_reg;
    logic [fmn_pkg::LEVEL_W-1:0]      min_dist_reg;
    logic [fmn_pkg::LEVEL_W-1:0]      level_reg;
    logic                             zero_reg;
    logic [fmn_pkg::NOTE_W-1:0]       note_reg;

    logic [fmn_pkg::PROD_W-1:0]       prod;
    logic [fmn_pkg::LEVEL_W-1:0]      target_ext;
    logic [fmn_pkg::LEVEL_W-1:0]      diff;
    logic                             take;
    logic signed [fmn_pkg::SUM_W-1:0] oct_ext;
    logic signed [fmn_pkg::SUM_W-1:0] note_sum;
    logic [fmn_pkg::NOTE_W-1:0]       note_sat;

    // Search status
    always_comb begin
        status.zero      = zero_reg;
        status.need_dbl  = ({1'b0, target_reg} >= {base_reg[fmn_pkg::BASE_W-2:0], 1'b0})
                           && !base_reg[fmn_pkg::BASE_W-1];
        status.need_hlv  = {1'b0, target_reg} < base_reg;
        status.last_semi = (semi_reg == fmn_pkg::LAST_SEMI);
    end

    // Semitone level: base * ratio / 1024
    assign prod = fmn_pkg::PROD_W'(base_reg) *
                  fmn_pkg::PROD_W'(fmn_pkg::semi_ratio(semi_reg));

    // Absolute distance; strict less keeps the lower semitone on a tie
    assign target_ext = fmn_pkg::LEVEL_W'(target_reg);
    assign diff = (target_ext > level_reg) ? (target_ext - level_reg)
                                           : (level_reg - target_ext);
    assign take = (semi_reg == '0) || (diff < min_dist_reg);

    // Note number and clamp
    assign oct_ext  = fmn_pkg::SUM_W'(oct_reg);
    assign note_sum = fmn_pkg::NOTE_A4 + oct_ext * fmn_pkg::SEMIS_OCT
                      + $signed(fmn_pkg::SUM_W'(best_reg));
    always_comb begin
        if (zero_reg || note_sum < 0) begin
            note_sat = '0;
        end else if (note_sum > fmn_pkg::NOTE_MAX) begin
            note_sat = fmn_pkg::NOTE_MAX[fmn_pkg::NOTE_W-1:0];
        end else begin
            note_sat = note_sum[fmn_pkg::NOTE_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            target_reg <= {s_freq_hz, fmn_pkg::FRAC_W'(0)};
            base_reg   <= fmn_pkg::BASE_A4;
            oct_reg    <= '0;
            semi_reg   <= '0;
            best_reg   <= '0;
            zero_reg   <= (s_freq_hz == '0);
        end
        if (cmd.dbl) begin
            base_reg <= {base_reg[fmn_pkg::BASE_W-2:0], 1'b0};
            oct_reg  <= oct_reg + fmn_pkg::OCT_W'(1);
        end
        if (cmd.hlv) begin
            base_reg <= {1'b0, base_reg[fmn_pkg::BASE_W-1:1]};
            oct_reg  <= oct_reg - fmn_pkg::OCT_W'(1);
        end
        if (cmd.mul) begin
            level_reg <= prod[fmn_pkg::PROD_W-1:fmn_pkg::RATIO_SHIFT];
        end
        if (cmd.cmp) begin
            if (take) begin
                best_reg     <= semi_reg;
                min_dist_reg <= diff;
            end
            semi_reg <= semi_reg + fmn_pkg::SEMI_W'(1);
        end
        if (cmd.out) begin
            note_reg <= note_sat;
        end
    end

    assign m_note = note_reg;

endmodule

@@ src/fmn_ctrl.sv @@
// Controller: sequences the octave search and semitone scan, owns the handshakes.
module fmn_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fmn_pkg::fmn_cmd_t     cmd,
    input  fmn_pkg::fmn_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_DOWN,
        ST_MUL,
        ST_CMP,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (status.zero) begin
                    state_next = ST_FIN;
                end else if (status.need_dbl) begin
                    cmd.dbl = 1'b1;
                end else begin
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (status.need_hlv) begin
                    cmd.hlv = 1'b1;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = status.last_semi ? ST_FIN : ST_MUL;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/frequency_to_midi_note_unit.sv @@
// Top level: frequency in hertz to nearest MIDI note number.
// Takes one 16-bit frequency word at a time and returns the nearest MIDI note (0..127),
// with zero mapped to note 0. From acceptance to result, the 440 Hz base is first doubled
// or halved one octave at a time (at most nine octaves), then the twelve semitones are
// scanned in turn; one multiplier forms each level and its result is registered
// before the distance compare. Silence skips the search. The result sits in an output
// register, so the next word is taken while it waits.
module frequency_to_midi_note_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fmn_pkg::FREQ_W-1:0]  s_freq_hz,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fmn_pkg::NOTE_W-1:0]  m_note
);

    fmn_pkg::fmn_cmd_t    cmd;
    fmn_pkg::fmn_status_t status;

    fmn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    fmn_datapath u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .status    (status),
        .s_freq_hz (s_freq_hz),
        .m_note    (m_note)
    );

endmodule

@@ src/fmn_checker.sv @@
// Port-level checker for the frequency-to-note unit, bound to the top level.
module fmn_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [fmn_pkg::FREQ_W-1:0]  s_freq_hz,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [fmn_pkg::NOTE_W-1:0]  m_note
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_note))
        else $error("result word changed while stalled");

    // One word in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in work");

    // Silence skips the search and gives note zero
    a_silence: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_freq_hz == '0 && !m_valid
        |-> ##3 (m_valid && m_note == '0))
        else $error("silence did not give note zero on time");

    // No result appears out of idle without a word
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid && !m_valid ##1 s_ready |-> !m_valid)
        else $error("result appeared with no word in work");

endmodule

bind frequency_to_midi_note_unit fmn_checker u_fmn_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_freq_hz (s_freq_hz),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_note    (m_note)
);

@@ dv/tb_frequency_to_midi_note_unit.sv @@
// Testbench for the frequency-to-MIDI-note unit: directed and random words, scoreboard check.
module tb_frequency_to_midi_note_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 50;      // longer than the slowest word
    localparam int IDLE_PCT     = 17;

    // Equal-tempered semitone ratios, times 1024; entry 0 is the unison
    localparam logic [11:0][10:0] SEMITONE_RATIO = {
        11'd1933, 11'd1824, 11'd1722, 11'd1625, 11'd1534, 11'd1448,
        11'd1366, 11'd1290, 11'd1217, 11'd1149, 11'd1085, 11'd1024
    };

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [fmn_pkg::FREQ_W-1:0]        s_freq_hz;
    logic                              m_valid;
    logic                              m_ready;
    logic [fmn_pkg::NOTE_W-1:0]        m_note;

    logic [fmn_pkg::NOTE_W-1:0]        expected_notes [$];
    int                                mismatch_count;
    int                                cycle_count;
    bit                                steady;     // no idling on either side

    frequency_to_midi_note_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_freq_hz (s_freq_hz),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_note    (m_note)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Nearest note: octave search on the 16.8 target, then closest semitone level
    function automatic logic [fmn_pkg::NOTE_W-1:0] nearest_note(
        input logic [fmn_pkg::FREQ_W-1:0] freq
    );
        longint unsigned target;
        longint unsigned base;
        longint unsigned level;
        longint unsigned diff;
        longint unsigned min_dist;
        int              octave;
        int              near_semi;
        int              note;
        int              semi;
        if (freq == '0) begin
            return '0;
        end
        target = longint'(freq) * 256;
        base   = longint'(440 * 256);
        octave = 0;
        while (target >= base * 2) begin
            base = base * 2;
            octave++;
        end
        while (base != 0 && target < base) begin
            base = base / 2;
            octave--;
        end
        min_dist  = '1;
        near_semi = 0;
        for (semi = 0; semi < 12; semi++) begin
            level = (base * longint'(SEMITONE_RATIO[semi])) / 1024;
            diff  = (target > level) ? target - level : level - target;
            // strict compare keeps the lower semitone on a tie
            if (diff < min_dist) begin
                min_dist  = diff;
                near_semi = semi;
            end
        end
        note = 69 + 12 * octave + near_semi;
        if (note < 0) begin
            note = 0;
        end
        if (note > 127) begin
            note = 127;
        end
        return fmn_pkg::NOTE_W'(note);
    endfunction

    // Random frequency: full range, musical range, near zero, near octave boundaries of A
    function automatic logic [fmn_pkg::FREQ_W-1:0] random_freq();
        int unsigned pick;
        int          boundary_hz;
        pick = $urandom_range(99);
        if (pick < 35) begin
            return fmn_pkg::FREQ_W'($urandom_range(65535));
        end else if (pick < 75) begin
            return fmn_pkg::FREQ_W'($urandom_range(4200, 20));
        end else if (pick < 85) begin
            return fmn_pkg::FREQ_W'($urandom_range(40, 0));
        end else begin
            boundary_hz = int'(55 << $urandom_range(10)) + int'($urandom_range(4)) - 2;
            return fmn_pkg::FREQ_W'(boundary_hz);
        end
    endfunction

    // Send one word; returns right after the edge that accepts it, valid still high
    task automatic send_freq(input logic [fmn_pkg::FREQ_W-1:0] freq);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_freq_hz <= freq;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_notes.push_back(nearest_note(freq));
    endtask

    // Lower valid and wait until every expected note has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_notes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Result side: random stalls, compare each accepted word with the oldest expectation
    initial begin
        logic [fmn_pkg::NOTE_W-1:0] want;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_notes.size() == 0) begin
                    $error("note: unexpected word, actual %0d", m_note);
                    mismatch_count++;
                end else begin
                    want = expected_notes.pop_front();
                    if (m_note !== want) begin
                        $error("note mismatch: expected %0d, actual %0d",
                               want, m_note);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Silence, all-zero and all-one words, alternating bit patterns
    task automatic test_silence_and_extremes();
        send_freq(16'h0000);
        send_freq(16'hFFFF);
        send_freq(16'h0001);
        send_freq(16'h8000);
        send_freq(16'h5555);
        send_freq(16'hAAAA);
        send_freq(16'h00FF);
        send_freq(16'hFF00);
    endtask

    // Notes that fall below 0 or above 127 saturate
    task automatic test_saturation();
        send_freq(16'd2);
        send_freq(16'd7);
        send_freq(16'd8);
        send_freq(16'd9);
        send_freq(16'd12543);
        send_freq(16'd12544);
        send_freq(16'd13290);
        send_freq(16'd30000);
    endtask

    // Words on and next to the octave boundaries of A, both search directions
    task automatic test_octave_boundaries();
        send_freq(16'd27);
        send_freq(16'd55);
        send_freq(16'd439);
        send_freq(16'd440);
        send_freq(16'd441);
        send_freq(16'd879);
        send_freq(16'd880);
        send_freq(16'd56320);
    endtask

    // One word at a time: sender holds off until the result is back
    task automatic test_isolated_words();
        repeat (20) begin
            send_freq(random_freq());
            wait_drained();
        end
    endtask

    // Random words with idling on both sides
    task automatic test_random_traffic();
        repeat (850) begin
            send_freq(random_freq());
        end
    endtask

    // Long stretch with no idling on either side
    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (300) begin
            send_freq(random_freq());
        end
        wait_drained();
        steady = 1'b0;
    endtask

    initial begin
        mismatch_count = 0;
        steady         = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_freq_hz <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_silence_and_extremes();
        test_saturation();
        test_octave_boundaries();
        test_isolated_words();
        test_random_traffic();
        test_back_to_back();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
